// ===== src/i2cmb_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
package i2cmb_pkg;

  // Register and field widths
  localparam int unsigned HP_W     = 16;
  localparam int unsigned PHASE_W  = 5;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Reset value of the half-period register
  localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd30;

  // Probe samples the slave ACK on this phase
  localparam logic [PHASE_W-1:0] PROBE_ACK_PHASE = 5'd28;

  // Command opcodes
  typedef enum logic [OP_W-1:0] {
    OP_START  = 3'd0,
    OP_STOP   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_READ   = 3'd3,
    OP_ACK    = 3'd4,
    OP_NACK   = 3'd5,
    OP_GETACK = 3'd6,
    OP_PROBE  = 3'd7
  } op_t;

  // Open-drain levels of the two bus lines
  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

endpackage

// ===== src/i2cmb_in_if.sv =====
// Tick channel into the bit engine: valid/ready plus one tick's payload.
interface i2cmb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd_valid;
  logic [i2cmb_pkg::OP_W-1:0]  opcode;
  logic [i2cmb_pkg::BYTE_W-1:0] cmd_data;
  logic                        sda_in;
  logic                        scl_in;

  modport source (output valid, cmd_valid, opcode, cmd_data, sda_in, scl_in, input ready);
  modport sink   (input valid, cmd_valid, opcode, cmd_data, sda_in, scl_in, output ready);
endinterface

// ===== src/i2cmb_out_if.sv =====
// Result channel out of the bit engine: valid/ready plus one tick's status.
interface i2cmb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         scl_release;
  logic                         sda_release;
  logic                         busy_res;
  logic                         done_res;
  logic [i2cmb_pkg::BYTE_W-1:0] rx_byte;
  logic                         ack_bit;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, rx_byte,
                  ack_bit, input ready);
  modport sink   (input valid, scl_release, sda_release, busy_res, done_res, rx_byte,
                  ack_bit, output ready);
endinterface

// ===== src/i2c_master_bit_engine_unit.sv =====
// I2C master bit engine top level: tick input register, sequencer, result register.
// Every transfer on in_ch is one bus tick; each tick yields exactly one result transfer
// on out_ch showing the line levels and status after that tick. The engine takes one
// tick per clock (throughput 1 item/cycle) unless out_ch stalls; a tick passes the
// input register, then the result register, with the sequencer update (phase counter,
// tick counter, shift byte) done in the single pass between them. Commands offered while
// a command runs are ignored. The half_period register (address 0, 16 bits, reset 30,
// zero acts as 1) sets the ticks per bit phase; write it only while the engine is idle.
module i2c_master_bit_engine_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  i2cmb_in_if.sink                          in_ch,
  i2cmb_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cmb_pkg::APB_AW-1:0]      paddr,
  input  logic [i2cmb_pkg::APB_DW-1:0]      pwdata,
  output logic [i2cmb_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);

  localparam int unsigned HW = i2cmb_pkg::HP_W;
  localparam int unsigned PW = i2cmb_pkg::PHASE_W;
  localparam int unsigned BW = i2cmb_pkg::BYTE_W;

  // ---------------------------------------------------------------------------
  // Phase entry helpers: each returns the new {scl, sda} levels
  // ---------------------------------------------------------------------------
  function automatic i2cmb_pkg::lines_t start_lv(logic [PW-1:0] k, i2cmb_pkg::lines_t cur);
    i2cmb_pkg::lines_t lv;
    lv = cur;
    if (k == 5'd0) begin
      lv.sda = 1'b1;
      lv.scl = 1'b1;
    end else if (k == 5'd1) begin
      lv.sda = 1'b0;
    end else begin
      lv.scl = 1'b0;
    end
    return lv;
  endfunction

  function automatic i2cmb_pkg::lines_t stop_lv(logic [PW-1:0] k, i2cmb_pkg::lines_t cur);
    i2cmb_pkg::lines_t lv;
    lv = cur;
    if (k == 5'd0) begin
      lv.sda = 1'b0;
      lv.scl = 1'b1;
    end else begin
      lv.sda = 1'b1;
    end
    return lv;
  endfunction

  function automatic i2cmb_pkg::lines_t clock_lv(logic [PW-1:0] k, logic sda_first,
                                                  i2cmb_pkg::lines_t cur);
    i2cmb_pkg::lines_t lv;
    lv = cur;
    if (k == 5'd0) begin
      lv.sda = sda_first;
    end else if (k == 5'd1) begin
      lv.scl = 1'b1;
    end else begin
      lv.scl = 1'b0;
    end
    return lv;
  endfunction

  // Write phase j: bit b = j/3 (via *11>>5, exact below 24), sub-step s = j%3
  function automatic i2cmb_pkg::lines_t write_lv(logic [PW-1:0] j, logic [BW-1:0] sb,
                                                  i2cmb_pkg::lines_t cur);
    i2cmb_pkg::lines_t lv;
    logic [8:0]        m;
    logic [2:0]        b;
    logic [PW-1:0]     r;
    lv = cur;
    m  = {4'd0, j} * 9'd11;
    b  = m[7:5];
    r  = j - ({1'b0, b, 1'b0} + {2'd0, b});
    if (r[1:0] == 2'd0) begin
      lv.sda = sb[3'd7 - b];
    end else if (r[1:0] == 2'd1) begin
      lv.scl = 1'b1;
    end else begin
      lv.scl = 1'b0;
      if (b == 3'd7) lv.sda = 1'b1;
    end
    return lv;
  endfunction

  function automatic i2cmb_pkg::lines_t enter_lv(i2cmb_pkg::op_t op, logic [PW-1:0] k,
                                                  logic [BW-1:0] sb, i2cmb_pkg::lines_t cur);
    i2cmb_pkg::lines_t lv;
    lv = cur;
    unique case (op)
      i2cmb_pkg::OP_START: lv = start_lv(k, cur);
      i2cmb_pkg::OP_STOP:  lv = stop_lv(k, cur);
      i2cmb_pkg::OP_WRITE: lv = write_lv(k, sb, cur);
      i2cmb_pkg::OP_READ: begin
        if (k == 5'd0) lv.sda = 1'b1;
        lv.scl = ~k[0];
      end
      i2cmb_pkg::OP_ACK:   lv = clock_lv(k, 1'b0, cur);
      i2cmb_pkg::OP_NACK,
      i2cmb_pkg::OP_GETACK: lv = clock_lv(k, 1'b1, cur);
      i2cmb_pkg::OP_PROBE: begin
        if (k < 5'd3)       lv = start_lv(k, cur);
        else if (k < 5'd27) lv = write_lv(k - 5'd3, sb, cur);
        else if (k < 5'd30) lv = clock_lv(k - 5'd27, 1'b1, cur);
        else                lv = stop_lv(k - 5'd30, cur);
      end
    endcase
    return lv;
  endfunction

  // Phases per command
  function automatic logic [i2cmb_pkg::LEN_W-1:0] op_len(i2cmb_pkg::op_t op);
    logic [i2cmb_pkg::LEN_W-1:0] n;
    unique case (op)
      i2cmb_pkg::OP_STOP:  n = 6'd2;
      i2cmb_pkg::OP_WRITE: n = 6'd24;
      i2cmb_pkg::OP_READ:  n = 6'd16;
      i2cmb_pkg::OP_PROBE: n = 6'd32;
      i2cmb_pkg::OP_START,
      i2cmb_pkg::OP_ACK,
      i2cmb_pkg::OP_NACK,
      i2cmb_pkg::OP_GETACK: n = 6'd3;
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [HW-1:0] half_period_r;
  logic          cfg_sel;

  assign cfg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? {{(i2cmb_pkg::APB_DW-HW){1'b0}}, half_period_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= i2cmb_pkg::HALF_PERIOD_RST;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      half_period_r <= pwdata[HW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic              s1_valid_r;
  logic              s1_cmd_valid_r;
  i2cmb_pkg::op_t    s1_opcode_r;
  logic [BW-1:0]     s1_data_r;
  logic              s1_sda_r;
  logic              s1_scl_r;
  logic              out_valid_r;
  logic              adv;

  // tick moves into the result register when that register is free or draining
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd_valid_r <= in_ch.cmd_valid;
      s1_opcode_r    <= i2cmb_pkg::op_t'(in_ch.opcode);
      s1_data_r      <= in_ch.cmd_data;
      s1_sda_r       <= in_ch.sda_in;
      s1_scl_r       <= in_ch.scl_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic              running_r,  running_nxt;
  logic [PW-1:0]     phase_r,    phase_nxt;
  logic [HW-1:0]     tick_r,     tick_nxt;
  logic [BW-1:0]     shift_r,    shift_nxt;
  i2cmb_pkg::op_t    op_r,       op_nxt;
  logic [BW-1:0]     rx_r,       rx_nxt;
  logic              ack_r,      ack_nxt;
  i2cmb_pkg::lines_t lines_r,    lines_nxt;
  logic              done_nxt;

  logic [HW-1:0]     hp_eff;
  logic [HW-1:0]     tick_inc;
  logic [PW-1:0]     phase_inc;

  assign hp_eff    = (half_period_r == '0) ? {{(HW-1){1'b0}}, 1'b1} : half_period_r;
  assign tick_inc  = tick_r + {{(HW-1){1'b0}}, 1'b1};
  assign phase_inc = phase_r + {{(PW-1){1'b0}}, 1'b1};

  // Next state for one tick
  always_comb begin
    running_nxt = running_r;
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    shift_nxt   = shift_r;
    op_nxt      = op_r;
    rx_nxt      = rx_r;
    ack_nxt     = ack_r;
    lines_nxt   = lines_r;
    done_nxt    = 1'b0;
    if (running_r) begin
      if (tick_inc >= hp_eff) begin
        tick_nxt = '0;
        // sampling at the end of the phase
        if (op_r == i2cmb_pkg::OP_READ && !phase_r[0]) begin
          shift_nxt = {shift_r[BW-2:0], s1_sda_r};
        end else if (op_r == i2cmb_pkg::OP_GETACK && phase_r == 5'd1) begin
          ack_nxt = s1_sda_r;
        end else if (op_r == i2cmb_pkg::OP_PROBE && phase_r == i2cmb_pkg::PROBE_ACK_PHASE) begin
          ack_nxt = s1_sda_r;
        end
        if (phase_inc == '0 || {1'b0, phase_inc} >= op_len(op_r)) begin
          running_nxt = 1'b0;
          phase_nxt   = '0;
          done_nxt    = 1'b1;
          if (op_r == i2cmb_pkg::OP_ACK)  lines_nxt.sda = 1'b1;
          if (op_r == i2cmb_pkg::OP_READ) rx_nxt = shift_nxt;
        end else begin
          phase_nxt = phase_inc;
          lines_nxt = enter_lv(op_r, phase_inc, shift_nxt, lines_r);
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end else if (s1_cmd_valid_r) begin
      op_nxt = s1_opcode_r;
      if (s1_opcode_r == i2cmb_pkg::OP_PROBE && !(s1_sda_r && s1_scl_r)) begin
        // bus not free: probe fails at once
        ack_nxt  = 1'b1;
        done_nxt = 1'b1;
      end else begin
        shift_nxt   = (s1_opcode_r == i2cmb_pkg::OP_READ) ? '0 : s1_data_r;
        phase_nxt   = '0;
        tick_nxt    = '0;
        running_nxt = 1'b1;
        lines_nxt   = enter_lv(s1_opcode_r, '0, shift_nxt, lines_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      phase_r   <= '0;
      tick_r    <= '0;
      shift_r   <= '0;
      op_r      <= i2cmb_pkg::OP_START;
      rx_r      <= '0;
      ack_r     <= 1'b1;
      lines_r   <= '{scl: 1'b1, sda: 1'b1};
    end else if (adv) begin
      running_r <= running_nxt;
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
      op_r      <= op_nxt;
      rx_r      <= rx_nxt;
      ack_r     <= ack_nxt;
      lines_r   <= lines_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic              out_busy_r;
  logic              out_done_r;
  logic [BW-1:0]     out_rx_r;
  logic              out_ack_r;
  i2cmb_pkg::lines_t out_lines_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_busy_r  <= running_nxt;
      out_done_r  <= done_nxt;
      out_rx_r    <= rx_nxt;
      out_ack_r   <= ack_nxt;
      out_lines_r <= lines_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scl_release = out_lines_r.scl;
  assign out_ch.sda_release = out_lines_r.sda;
  assign out_ch.busy_res    = out_busy_r;
  assign out_ch.done_res    = out_done_r;
  assign out_ch.rx_byte     = out_rx_r;
  assign out_ch.ack_bit     = out_ack_r;

endmodule

// ===== src/i2cmb_checker.sv =====
// Port-level checker for the I2C master bit engine, bound to the top level.
module i2cmb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         scl_release,
  input logic                         sda_release,
  input logic                         busy_res,
  input logic                         done_res,
  input logic [i2cmb_pkg::BYTE_W-1:0] rx_byte,
  input logic                         ack_bit
);

  // a finishing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(done_res && busy_res))
    else $error("done and busy both set");

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(scl_release) && $stable(sda_release)
      && $stable(busy_res) && $stable(done_res) && $stable(rx_byte) && $stable(ack_bit))
    else $error("result changed while stalled");

  // nothing shows right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a tick entering an empty result stage shows a result after passing the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("tick not delivered");

endmodule

bind i2c_master_bit_engine_unit i2cmb_checker u_i2cmb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .scl_release (out_ch.scl_release),
  .sda_release (out_ch.sda_release),
  .busy_res    (out_ch.busy_res),
  .done_res    (out_ch.done_res),
  .rx_byte     (out_ch.rx_byte),
  .ack_bit     (out_ch.ack_bit)
);

// ===== sim/i2cmb_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the I2C bit engine: per-tick prediction of line levels and status, result compare.
module i2cmb_scoreboard
  import i2cmb_pkg::*;
#(
  parameter logic [APB_AW-1:0] HP_ADDR = '0
) (
  input  logic              clk,
  input  logic              rst_n,
  i2cmb_in_if               in_mon,
  i2cmb_out_if              out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int unsigned       fail_count,
  output logic              engine_busy,
  output int unsigned       results_owed
);

  // What the engine shows after one tick
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx;
    logic              ack;
  } tick_status_t;

  tick_status_t status_q[$];

  // Sequencer mirror
  logic [HP_W-1:0]    hp_reg;
  logic               running;
  logic [PHASE_W-1:0] phase;
  logic [HP_W-1:0]    tick_cnt;
  logic [BYTE_W-1:0]  shreg;
  logic [BYTE_W-1:0]  rx_hold;
  op_t                cur_op;
  logic               ack_flag;
  logic               scl_lvl;
  logic               sda_lvl;

  function automatic void clear_model();
    hp_reg   = HALF_PERIOD_RST;
    running  = 1'b0;
    phase    = '0;
    tick_cnt = '0;
    shreg    = '0;
    rx_hold  = '0;
    cur_op   = OP_START;
    ack_flag = 1'b1;
    scl_lvl  = 1'b1;
    sda_lvl  = 1'b1;
  endfunction

  // Number of bit phases in each command
  function automatic int unsigned seq_phases(op_t op);
    case (op)
      OP_START: return 3;
      OP_STOP:  return 2;
      OP_WRITE: return 24;
      OP_READ:  return 16;
      OP_PROBE: return 32;
      default:  return 3;
    endcase
  endfunction

  function automatic void start_lines(int unsigned k);
    if (k == 0) begin
      sda_lvl = 1'b1;
      scl_lvl = 1'b1;
    end else if (k == 1) begin
      sda_lvl = 1'b0;
    end else begin
      scl_lvl = 1'b0;
    end
  endfunction

  function automatic void stop_lines(int unsigned k);
    if (k == 0) begin
      sda_lvl = 1'b0;
      scl_lvl = 1'b1;
    end else begin
      sda_lvl = 1'b1;
    end
  endfunction

  // Three phases per bit: set data, SCL high, SCL low (SDA let go after the last bit)
  function automatic void write_lines(int unsigned j);
    int unsigned b;
    int unsigned s;
    b = j / 3;
    s = j % 3;
    if (s == 0) begin
      sda_lvl = shreg[7 - (b % 8)];
    end else if (s == 1) begin
      scl_lvl = 1'b1;
    end else begin
      scl_lvl = 1'b0;
      if (b == 7) sda_lvl = 1'b1;
    end
  endfunction

  function automatic void clock_lines(int unsigned k, logic sda_first);
    if (k == 0) sda_lvl = sda_first;
    else if (k == 1) scl_lvl = 1'b1;
    else scl_lvl = 1'b0;
  endfunction

  function automatic void enter_phase(op_t op, int unsigned k);
    case (op)
      OP_START: start_lines(k);
      OP_STOP:  stop_lines(k);
      OP_WRITE: write_lines(k);
      OP_READ: begin
        if (k == 0) sda_lvl = 1'b1;
        scl_lvl = (k % 2 == 0);
      end
      OP_ACK:   clock_lines(k, 1'b0);
      OP_PROBE: begin
        if (k < 3) start_lines(k);
        else if (k < 27) write_lines(k - 3);
        else if (k < 30) clock_lines(k - 27, 1'b1);
        else stop_lines(k - 30);
      end
      default:  clock_lines(k, 1'b1);
    endcase
  endfunction

  // Sampling at the end of a phase
  function automatic void exit_phase(op_t op, logic [PHASE_W-1:0] k, logic sda);
    if (op == OP_READ && k[0] == 1'b0) shreg = {shreg[BYTE_W-2:0], sda};
    else if (op == OP_GETACK && k == 1) ack_flag = sda;
    else if (op == OP_PROBE && k == PROBE_ACK_PHASE) ack_flag = sda;
  endfunction

  // One bus tick through the sequencer
  function automatic tick_status_t advance_tick(logic cv, op_t op, logic [BYTE_W-1:0] data,
                                                logic sda, logic scl);
    logic [HP_W-1:0] hp_eff;
    logic            done;
    tick_status_t    st;
    hp_eff = (hp_reg == '0) ? HP_W'(1) : hp_reg;
    done   = 1'b0;
    if (running) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= hp_eff) begin
        tick_cnt = '0;
        exit_phase(cur_op, phase, sda);
        phase = phase + 1'b1;
        if (phase == '0 || phase >= seq_phases(cur_op)) begin
          running = 1'b0;
          phase   = '0;
          done    = 1'b1;
          if (cur_op == OP_ACK) sda_lvl = 1'b1;
          if (cur_op == OP_READ) rx_hold = shreg;
        end else begin
          enter_phase(cur_op, phase);
        end
      end
    end else if (cv) begin
      cur_op = op;
      if (op == OP_PROBE && !(sda && scl)) begin
        // bus not free: probe gives up at once
        ack_flag = 1'b1;
        done     = 1'b1;
      end else begin
        shreg    = (op == OP_READ) ? '0 : data;
        phase    = '0;
        tick_cnt = '0;
        running  = 1'b1;
        enter_phase(op, 0);
      end
    end
    st.scl  = scl_lvl;
    st.sda  = sda_lvl;
    st.busy = running;
    st.done = done;
    st.rx   = rx_hold;
    st.ack  = ack_flag;
    return st;
  endfunction

  function automatic string fmt_status(tick_status_t s);
    return $sformatf("scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b",
                     s.scl, s.sda, s.busy, s.done, s.rx, s.ack);
  endfunction

  function automatic string diff_fields(tick_status_t want, tick_status_t got);
    string d;
    d = "";
    if (got.scl !== want.scl) d = {d, " scl"};
    if (got.sda !== want.sda) d = {d, " sda"};
    if (got.busy !== want.busy) d = {d, " busy"};
    if (got.done !== want.done) d = {d, " done"};
    if (got.rx !== want.rx) d = {d, " rx"};
    if (got.ack !== want.ack) d = {d, " ack"};
    return d;
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count < 10) $display("[%0t] %s", $realtime, msg);
    fail_count++;
  endfunction

  // Register writes, result compare, then prediction for the accepted tick
  always @(posedge clk) begin
    tick_status_t want;
    tick_status_t got;
    string        d;
    if (!rst_n) begin
      clear_model();
      status_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == HP_ADDR)
        hp_reg = pwdata[HP_W-1:0];

      if (out_mon.valid && out_mon.ready) begin
        got.scl  = out_mon.scl_release;
        got.sda  = out_mon.sda_release;
        got.busy = out_mon.busy_res;
        got.done = out_mon.done_res;
        got.rx   = out_mon.rx_byte;
        got.ack  = out_mon.ack_bit;
        if (status_q.size() == 0) begin
          note_failure({"result transfer with nothing expected: ", fmt_status(got)});
        end else begin
          want = status_q.pop_front();
          d = diff_fields(want, got);
          if (d != "")
            note_failure({"mismatch in", d, "\n  expected ", fmt_status(want),
                          "\n  actual   ", fmt_status(got)});
        end
      end

      if (in_mon.valid && in_mon.ready)
        status_q.push_back(advance_tick(in_mon.cmd_valid, op_t'(in_mon.opcode),
                                        in_mon.cmd_data, in_mon.sda_in, in_mon.scl_in));
    end
    engine_busy  = running;
    results_owed = status_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, tick stimulus, half-period register setup and the verdict.
module tb;
  import i2cmb_pkg::*;

  localparam logic [APB_AW-1:0] HALF_PERIOD_ADDR = '0;

  // Half-period settings and random tick counts of the random phases
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned HP_PLAN [N_PHASES]   = '{1, 0, 2, 3, 7, 1};
  localparam int unsigned TICK_PLAN [N_PHASES] = '{250, 200, 200, 150, 150, 150};
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WIDE_TICKS  = 50;

  // SDA level driven on the ticks of a running command
  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND} sda_fill_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bit calm;      // no idling on either side
  bit hold_req;  // asks the result side for a long hold-off

  int unsigned fail_count;
  int unsigned results_owed;
  logic        engine_busy;

  i2cmb_in_if  in_ch();
  i2cmb_out_if out_ch();

  i2c_master_bit_engine_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  i2cmb_scoreboard #(
    .HP_ADDR (HALF_PERIOD_ADDR)
  ) u_scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .engine_busy  (engine_busy),
    .results_owed (results_owed)
  );

  always #1 clk = ~clk;

  // Hard stop in case the run hangs
  initial begin : run_limit
    #3_000_000;
    $display("FAIL i2c_master_bit_engine_unit");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  // One tick transfer; starts and ends at a falling edge
  task automatic send_tick(input logic cv, input logic [OP_W-1:0] op,
                           input logic [BYTE_W-1:0] data, input logic sda, input logic scl);
    while (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd_valid <= cv;
    in_ch.opcode    <= op;
    in_ch.cmd_data  <= data;
    in_ch.sda_in    <= sda;
    in_ch.scl_in    <= scl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Tick the engine until the running command finishes; stray commands get ignored
  task automatic drain_engine(input sda_fill_t fill);
    logic s;
    while (engine_busy) begin
      case (fill)
        SDA_LOW:  s = 1'b0;
        SDA_HIGH: s = 1'b1;
        default:  s = 1'($urandom_range(1));
      endcase
      send_tick(1'($urandom_range(1)), OP_W'($urandom_range(7)),
                BYTE_W'($urandom_range(255)), s, 1'($urandom_range(1)));
    end
  endtask

  task automatic run_cmd(input op_t op, input logic [BYTE_W-1:0] data, input logic sda,
                         input logic scl, input sda_fill_t fill);
    send_tick(1'b1, op, data, sda, scl);
    drain_engine(fill);
  endtask

  // Bring the engine to rest and let every result come out
  task automatic settle();
    drain_engine(SDA_RAND);
    in_ch.valid <= 1'b0;
    wait (results_owed == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_half_period(input logic [HP_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HALF_PERIOD_ADDR;
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly ticks with no command; probes mostly see a free bus
  task automatic send_random_tick();
    logic              cv;
    logic [OP_W-1:0]   op;
    logic              sda;
    logic              scl;
    cv  = ($urandom_range(99) < 35);
    op  = OP_W'($urandom_range(7));
    sda = 1'($urandom_range(1));
    scl = 1'($urandom_range(1));
    if (cv && op == OP_PROBE && $urandom_range(99) < 80) begin
      sda = 1'b1;
      scl = 1'b1;
    end
    send_tick(cv, op, BYTE_W'($urandom_range(255)), sda, scl);
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd_valid = 1'b0;
    in_ch.opcode    = '0;
    in_ch.cmd_data  = '0;
    in_ch.sda_in    = 1'b1;
    in_ch.scl_in    = 1'b1;
    calm            = 1'b0;
    hold_req        = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset half-period still in force
    run_cmd(OP_START, 8'h00, 1'b1, 1'b1, SDA_RAND);
    settle();
    write_half_period(HP_W'(1));

    // directed: every command, byte extremes, read/ack sampling, probe cases
    run_cmd(OP_START, 8'h00, 1'b1, 1'b1, SDA_RAND);
    run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0, SDA_RAND);
    run_cmd(OP_WRITE, 8'h00, 1'b0, 1'b1, SDA_RAND);
    run_cmd(OP_WRITE, 8'hFF, 1'b1, 1'b0, SDA_RAND);
    run_cmd(OP_WRITE, 8'hA5, 1'b1, 1'b1, SDA_RAND);
    run_cmd(OP_READ, 8'hFF, 1'b1, 1'b1, SDA_HIGH);
    run_cmd(OP_READ, 8'h3C, 1'b0, 1'b1, SDA_LOW);
    run_cmd(OP_READ, 8'h00, 1'b1, 1'b1, SDA_RAND);
    run_cmd(OP_ACK, 8'h00, 1'b1, 1'b1, SDA_RAND);
    run_cmd(OP_NACK, 8'hFF, 1'b1, 1'b1, SDA_RAND);
    run_cmd(OP_GETACK, 8'h00, 1'b1, 1'b1, SDA_LOW);
    run_cmd(OP_GETACK, 8'h00, 1'b1, 1'b1, SDA_HIGH);
    // probe on a busy bus fails on the spot
    run_cmd(OP_PROBE, 8'hA0, 1'b0, 1'b1, SDA_RAND);
    run_cmd(OP_PROBE, 8'hA0, 1'b1, 1'b0, SDA_RAND);
    run_cmd(OP_PROBE, 8'hA0, 1'b0, 1'b0, SDA_RAND);
    // probe on a free bus, acked and not acked
    run_cmd(OP_PROBE, 8'hFF, 1'b1, 1'b1, SDA_LOW);
    run_cmd(OP_PROBE, 8'h00, 1'b1, 1'b1, SDA_HIGH);
    run_cmd(OP_PROBE, 8'hA0, 1'b1, 1'b1, SDA_RAND);
    // command offered while another one runs
    send_tick(1'b1, OP_WRITE, 8'h5A, 1'b1, 1'b1);
    send_tick(1'b1, OP_PROBE, 8'hC3, 1'b1, 1'b1);
    drain_engine(SDA_RAND);

    // random phases over several half-period settings
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_half_period(HP_W'(HP_PLAN[p]));
      calm = (p == 2);
      for (int unsigned t = 0; t < TICK_PLAN[p]; t++) begin
        if (p == 0 && t == 100) hold_req = 1'b1;
        send_random_tick();
      end
      calm = 1'b0;
    end

    // widest half-period: a probe on a busy bus, then a stop that is still in its
    // first phase when the run ends
    settle();
    write_half_period(16'hFFFF);
    run_cmd(OP_PROBE, 8'hA0, 1'b0, 1'b1, SDA_RAND);
    send_tick(1'b1, OP_STOP, 8'h00, 1'b1, 1'b1);
    for (int unsigned t = 0; t < WIDE_TICKS; t++) begin
      send_random_tick();
    end

    in_ch.valid <= 1'b0;
    wait (results_owed == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("PASS i2c_master_bit_engine_unit");
    end else begin
      $display("FAIL i2c_master_bit_engine_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/i2cmb_pkg.sv
src/i2cmb_in_if.sv
src/i2cmb_out_if.sv
src/i2c_master_bit_engine_unit.sv
src/i2cmb_checker.sv
sim/i2cmb_scoreboard.sv
sim/tb.sv
